// File: rtl/ffc_pkg.sv
// ----------------------------------------------------------------------------
// Formation follow controller package
// Shared angle constants, the CORDIC arctangent table, register indexes and
// the sideband types carried along the pipeline.
// ----------------------------------------------------------------------------
package ffc_pkg;

	localparam int DEF_FRAC_BITS = 16;
	localparam int ANG_BITS      = 30;
	localparam int ANG_W         = 35;
	localparam int CORDIC_STAGES = 30;
	localparam int PRESCALE      = 24;

	localparam logic signed [ANG_W-1:0] PI_A      = 35'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_A = 35'sd1686629713;
	localparam logic signed [ANG_W-1:0] TWO_PI_A  = 35'sd6746518852;
	localparam logic signed [ANG_W-1:0] GAIN_K    = 35'sd652032874;

	localparam logic signed [ANG_W-1:0] ARCTAB [CORDIC_STAGES] = '{
		35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
		35'sd67021687, 35'sd33543516, 35'sd16775851, 35'sd8388437,
		35'sd4194283, 35'sd2097149, 35'sd1048576, 35'sd524288,
		35'sd262144, 35'sd131072, 35'sd65536, 35'sd32768,
		35'sd16384, 35'sd8192, 35'sd4096, 35'sd2048,
		35'sd1024, 35'sd512, 35'sd256, 35'sd128,
		35'sd64, 35'sd32, 35'sd16, 35'sd8,
		35'sd4, 35'sd2
	};

	typedef enum logic [2:0] {
		REG_OFFSET_FORWARD = 3'd0,
		REG_OFFSET_LATERAL = 3'd1,
		REG_ERROR_GAIN     = 3'd2,
		REG_WIDTH_LIMIT    = 3'd3,
		REG_FORCED_TURN    = 3'd4
	} cfg_reg_t;

	localparam logic signed [31:0] RST_OFFSET_FORWARD = 32'sd196608;
	localparam logic signed [31:0] RST_OFFSET_LATERAL = 32'sd131072;
	localparam logic [20:0]        RST_ERROR_GAIN     = 21'd13107;
	localparam logic [30:0]        RST_WIDTH_LIMIT    = 31'd131072;
	localparam logic signed [17:0] RST_FORCED_TURN    = 18'sd65536;

	typedef struct packed {
		logic signed [31:0]      px;
		logic signed [31:0]      py;
		logic signed [31:0]      v;
		logic signed [31:0]      rate;
		logic signed [31:0]      ex_p;
		logic signed [31:0]      ey_p;
		logic signed [31:0]      es;
		logic [30:0]             widest;
		logic signed [ANG_W-1:0] ew;
		logic                    neg;
	} side_t;

	typedef struct packed {
		logic signed [31:0]      es;
		logic [30:0]             widest;
		logic signed [ANG_W-1:0] ew;
		logic                    zero;
	} vside_t;

	function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
		if (v > 72'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -72'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

// File: rtl/formation_follow_controller_unit.sv
// ----------------------------------------------------------------------------
// Formation follow controller
// Places a target point in the leader's body frame, forms the guidance vector
// and derives speed and turn commands for the follower.
//
//   Channel   Handshake                    Payload
//   item      item_valid / item_ready      leader pose and rates, estimate
//   result    result_valid / result_ready  speed_command, turn_command, flag
//   config    cfg_we                       cfg_index, cfg_data
//
// One transaction per cycle is accepted while item_ready is high; each result
// passes through the angle reduction and the three 30-stage CORDIC pipelines
// before it reaches the output register.
// Reset clears the valid bits and the registers; the data path is not reset.
// A full skid stage freezes the pipeline and drops item_ready until the
// waiting result is taken.
// ----------------------------------------------------------------------------
module formation_follow_controller_unit
	import ffc_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic signed [31:0] leader_px,
	input  logic signed [31:0] leader_py,
	input  logic signed [31:0] leader_speed,
	input  logic signed [31:0] leader_heading,
	input  logic signed [31:0] leader_turn_rate,
	input  logic signed [31:0] est_px,
	input  logic signed [31:0] est_py,
	input  logic signed [31:0] est_speed,
	input  logic signed [31:0] est_heading,
	input  logic [30:0]        est_widest,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [17:0] speed_command,
	output logic signed [17:0] turn_command,
	output logic               estimate_too_wide
);

	localparam int L_RED = ANG_BITS - FRAC_BITS + 3;
	localparam int LAT   = L_RED + 102;
	localparam int VX_W  = 59;

	logic signed [31:0] offset_forward_q;
	logic signed [31:0] offset_lateral_q;
	logic [20:0]        error_gain_q;
	logic [30:0]        width_limit_q;
	logic signed [17:0] forced_turn_q;

	logic           adv;
	logic [LAT-1:0] v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_forward_q <= RST_OFFSET_FORWARD;
			offset_lateral_q <= RST_OFFSET_LATERAL;
			error_gain_q     <= RST_ERROR_GAIN;
			width_limit_q    <= RST_WIDTH_LIMIT;
			forced_turn_q    <= RST_FORCED_TURN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OFFSET_FORWARD: offset_forward_q <= cfg_data;
				REG_OFFSET_LATERAL: offset_lateral_q <= cfg_data;
				REG_ERROR_GAIN:     error_gain_q     <= cfg_data[20:0];
				REG_WIDTH_LIMIT:    width_limit_q    <= cfg_data[30:0];
				REG_FORCED_TURN:    forced_turn_q    <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// Heading reduction, stage group 1.
	side_t                   side_in;
	side_t                   side_s1 [L_RED];
	logic signed [ANG_W-1:0] wrap_h;
	logic signed [ANG_W-1:0] wrap_e;

	always_comb begin
		side_in        = '0;
		side_in.px     = leader_px;
		side_in.py     = leader_py;
		side_in.v      = leader_speed;
		side_in.rate   = leader_turn_rate;
		side_in.ex_p   = est_px;
		side_in.ey_p   = est_py;
		side_in.es     = est_speed;
		side_in.widest = est_widest;
	end

	ffc_angle_mod #(.FRAC_BITS(FRAC_BITS)) u_mod_h (
		.clk(clk), .en(adv), .angle(leader_heading), .wrapped(wrap_h)
	);

	ffc_angle_mod #(.FRAC_BITS(FRAC_BITS)) u_mod_e (
		.clk(clk), .en(adv), .angle(est_heading), .wrapped(wrap_e)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1[0] <= side_in;
			for (int i = 1; i < L_RED; i++) begin
				side_s1[i] <= side_s1[i-1];
			end
		end
	end

	// Quadrant fold into the CORDIC range.
	logic signed [ANG_W-1:0] z_s2;
	side_t                   side_fold;
	side_t                   side_s2;

	always_comb begin
		side_fold     = side_s1[L_RED-1];
		side_fold.ew  = wrap_e;
		side_fold.neg = (wrap_h > HALF_PI_A) || (wrap_h < -HALF_PI_A);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_fold;
			if (wrap_h > HALF_PI_A) begin
				z_s2 <= wrap_h - PI_A;
			end else if (wrap_h < -HALF_PI_A) begin
				z_s2 <= wrap_h + PI_A;
			end else begin
				z_s2 <= wrap_h;
			end
		end
	end

	// Sine and cosine.
	logic signed [32:0]      rx;
	logic signed [32:0]      ry;
	logic signed [ANG_W-1:0] rz;
	side_t                   side_s3 [CORDIC_STAGES];

	ffc_cordic #(.XY_W(33), .VECTORING(1'b0)) u_rot (
		.clk(clk), .en(adv), .x_in(33'(GAIN_K)), .y_in(33'sd0), .z_in(z_s2),
		.x_out(rx), .y_out(ry), .z_out(rz)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3[0] <= side_s2;
			for (int i = 1; i < CORDIC_STAGES; i++) begin
				side_s3[i] <= side_s3[i-1];
			end
		end
	end

	logic signed [32:0] c_s4;
	logic signed [32:0] s_s4;
	side_t              side_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s4    <= side_s3[CORDIC_STAGES-1].neg ? -rx : rx;
			s_s4    <= side_s3[CORDIC_STAGES-1].neg ? -ry : ry;
			side_s4 <= side_s3[CORDIC_STAGES-1];
		end
	end

	// Target offset, target velocity and guidance vector.
	logic signed [64:0] pcf_s5, psl_s5, psf_s5, pcl_s5, vc_s5, vs_s5;
	side_t              side_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			pcf_s5  <= c_s4 * offset_forward_q;
			psl_s5  <= s_s4 * offset_lateral_q;
			psf_s5  <= s_s4 * offset_forward_q;
			pcl_s5  <= c_s4 * offset_lateral_q;
			vc_s5   <= c_s4 * side_s4.v;
			vs_s5   <= s_s4 * side_s4.v;
			side_s5 <= side_s4;
		end
	end

	logic signed [65:0] dxf, dyf;
	logic signed [35:0] dx_s6, dy_s6, vcq_s6, vsq_s6;
	side_t              side_s6;

	assign dxf = pcf_s5 - psl_s5;
	assign dyf = psf_s5 + pcl_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s6   <= 36'(dxf >>> ANG_BITS);
			dy_s6   <= 36'(dyf >>> ANG_BITS);
			vcq_s6  <= 36'(vc_s5 >>> ANG_BITS);
			vsq_s6  <= 36'(vs_s5 >>> ANG_BITS);
			side_s6 <= side_s5;
		end
	end

	logic signed [67:0] rdy_s7, rdx_s7;
	logic signed [37:0] ex_s7, ey_s7;
	logic signed [35:0] vcq_s7, vsq_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			rdy_s7 <= side_s6.rate * dy_s6;
			rdx_s7 <= side_s6.rate * dx_s6;
			ex_s7  <= side_s6.px + dx_s6 - side_s6.ex_p;
			ey_s7  <= side_s6.py + dy_s6 - side_s6.ey_p;
			vcq_s7 <= vcq_s6;
			vsq_s7 <= vsq_s6;
		end
	end

	side_t side_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s7 <= side_s6;
		end
	end

	logic signed [68:0] qvx_s8, qvy_s8;
	logic signed [59:0] gex_s8, gey_s8;
	logic signed [21:0] gain_sg;
	side_t              side_s8;

	assign gain_sg = signed'({1'b0, error_gain_q});

	always_ff @(posedge clk) begin
		if (adv) begin
			qvx_s8  <= vcq_s7 - (rdy_s7 >>> FRAC_BITS);
			qvy_s8  <= vsq_s7 + (rdx_s7 >>> FRAC_BITS);
			gex_s8  <= gain_sg * ex_s7;
			gey_s8  <= gain_sg * ey_s7;
			side_s8 <= side_s7;
		end
	end

	logic signed [71:0] sumx, sumy;
	logic signed [31:0] wx_s9, wy_s9;
	side_t              side_s9;

	assign sumx = qvx_s8 + (gex_s8 >>> FRAC_BITS);
	assign sumy = qvy_s8 + (gey_s8 >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s9   <= sat32(sumx);
			wy_s9   <= sat32(sumy);
			side_s9 <= side_s8;
		end
	end

	// Bearing and magnitude of the guidance vector.
	logic signed [VX_W-1:0]  xw, yw;
	logic signed [VX_W-1:0]  xa_s10, ya_s10;
	logic signed [ANG_W-1:0] za_s10;
	vside_t                  vside_s10;

	assign xw = VX_W'(wx_s9) <<< PRESCALE;
	assign yw = VX_W'(wy_s9) <<< PRESCALE;

	always_ff @(posedge clk) begin
		if (adv) begin
			vside_s10.es     <= side_s9.es;
			vside_s10.widest <= side_s9.widest;
			vside_s10.ew     <= side_s9.ew;
			vside_s10.zero   <= (wx_s9 == 32'sd0) && (wy_s9 == 32'sd0);
			if (wx_s9 < 0) begin
				xa_s10 <= -xw;
				ya_s10 <= -yw;
				za_s10 <= (wy_s9 >= 0) ? PI_A : -PI_A;
			end else begin
				xa_s10 <= xw;
				ya_s10 <= yw;
				za_s10 <= '0;
			end
		end
	end

	logic signed [VX_W-1:0]  vax, vay;
	logic signed [ANG_W-1:0] vaz;
	vside_t                  vside_s11 [CORDIC_STAGES];

	ffc_cordic #(.XY_W(VX_W), .VECTORING(1'b1)) u_vec_a (
		.clk(clk), .en(adv), .x_in(xa_s10), .y_in(ya_s10), .z_in(za_s10),
		.x_out(vax), .y_out(vay), .z_out(vaz)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			vside_s11[0] <= vside_s10;
			for (int i = 1; i < CORDIC_STAGES; i++) begin
				vside_s11[i] <= vside_s11[i-1];
			end
		end
	end

	vside_t                  va_end;
	logic signed [34:0]      xsh;
	logic signed [ANG_W-1:0] bear;
	logic signed [65:0]      prod_s12;
	logic signed [ANG_W-1:0] diff_s12;
	logic signed [31:0]      es_s12;
	logic [30:0]             widest_s12;

	assign va_end = vside_s11[CORDIC_STAGES-1];
	assign xsh    = 35'(vax >>> PRESCALE);
	assign bear   = va_end.zero ? '0 : vaz;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s12   <= xsh * GAIN_K;
			diff_s12   <= bear - va_end.ew;
			es_s12     <= va_end.es;
			widest_s12 <= va_end.widest;
		end
	end

	logic signed [71:0]      argf;
	logic signed [31:0]      arg_s13;
	logic signed [ANG_W-1:0] t1_s13;
	logic [30:0]             widest_s13;

	assign argf = 36'(prod_s12 >>> ANG_BITS) - es_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			arg_s13    <= sat32(argf);
			widest_s13 <= widest_s12;
			if (diff_s12 >= TWO_PI_A) begin
				t1_s13 <= diff_s12 - TWO_PI_A;
			end else if (diff_s12 <= -TWO_PI_A) begin
				t1_s13 <= diff_s12 + TWO_PI_A;
			end else begin
				t1_s13 <= diff_s12;
			end
		end
	end

	// Arctangent of the speed error.
	logic signed [VX_W-1:0]  xb_s14, yb_s14;
	logic signed [ANG_W-1:0] dang_s14;
	logic [30:0]             widest_s14;

	always_ff @(posedge clk) begin
		if (adv) begin
			xb_s14     <= VX_W'(1) <<< (FRAC_BITS + PRESCALE);
			yb_s14     <= VX_W'(arg_s13) <<< PRESCALE;
			widest_s14 <= widest_s13;
			if (t1_s13 > PI_A) begin
				dang_s14 <= t1_s13 - TWO_PI_A;
			end else if (t1_s13 <= -PI_A) begin
				dang_s14 <= t1_s13 + TWO_PI_A;
			end else begin
				dang_s14 <= t1_s13;
			end
		end
	end

	logic signed [VX_W-1:0]  vbx, vby;
	logic signed [ANG_W-1:0] vbz;
	logic signed [ANG_W-1:0] dang_s15 [CORDIC_STAGES];
	logic [30:0]             widest_s15 [CORDIC_STAGES];

	ffc_cordic #(.XY_W(VX_W), .VECTORING(1'b1)) u_vec_b (
		.clk(clk), .en(adv), .x_in(xb_s14), .y_in(yb_s14), .z_in('0),
		.x_out(vbx), .y_out(vby), .z_out(vbz)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			dang_s15[0]   <= dang_s14;
			widest_s15[0] <= widest_s14;
			for (int i = 1; i < CORDIC_STAGES; i++) begin
				dang_s15[i]   <= dang_s15[i-1];
				widest_s15[i] <= widest_s15[i-1];
			end
		end
	end

	// Rounding and forced turn selection.
	localparam logic signed [ANG_W-1:0] RND_S = ANG_W'(1) <<< (ANG_BITS - FRAC_BITS - 1);
	localparam logic signed [ANG_W-1:0] RND_T = ANG_W'(1) <<< (ANG_BITS - FRAC_BITS);

	logic signed [ANG_W-1:0] spd_r, trn_r;
	logic                    wide;
	logic signed [17:0]      speed_s16, turn_s16;
	logic                    flag_s16;

	assign spd_r = (vbz + RND_S) >>> (ANG_BITS - FRAC_BITS);
	assign trn_r = (dang_s15[CORDIC_STAGES-1] + RND_T) >>> (ANG_BITS + 1 - FRAC_BITS);
	assign wide  = widest_s15[CORDIC_STAGES-1] > width_limit_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			speed_s16 <= spd_r[17:0];
			turn_s16  <= wide ? forced_turn_q : trn_r[17:0];
			flag_s16  <= wide;
		end
	end

	// Valid bits, output register and skid stage.
	logic               res_v_q, skid_v_q;
	logic signed [17:0] res_speed_q, res_turn_q, skid_speed_q, skid_turn_q;
	logic               res_flag_q, skid_flag_q;

	assign adv        = !skid_v_q;
	assign item_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[LAT-2:0], item_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			if (res_v_q && !result_ready) begin
				skid_v_q <= v_q[LAT-1];
			end else begin
				res_v_q <= v_q[LAT-1];
			end
		end else if (result_ready) begin
			res_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			if (res_v_q && !result_ready) begin
				skid_speed_q <= speed_s16;
				skid_turn_q  <= turn_s16;
				skid_flag_q  <= flag_s16;
			end else begin
				res_speed_q <= speed_s16;
				res_turn_q  <= turn_s16;
				res_flag_q  <= flag_s16;
			end
		end else if (result_ready) begin
			res_speed_q <= skid_speed_q;
			res_turn_q  <= skid_turn_q;
			res_flag_q  <= skid_flag_q;
		end
	end

	assign result_valid      = res_v_q;
	assign speed_command     = res_speed_q;
	assign turn_command      = res_turn_q;
	assign estimate_too_wide = res_flag_q;

	a_skid_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> res_v_q)
		else $error("Skid stage holds a transaction while the output register is empty.");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && result_ready |=> res_v_q && !skid_v_q)
		else $error("Skid stage did not drain into the output register.");

	a_frozen_pipeline: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |=> $stable(v_q))
		else $error("Pipeline moved while the skid stage was full.");

endmodule

// File: rtl/ffc_angle_mod.sv
// ----------------------------------------------------------------------------
// Angle reduction pipeline
// Scales a fixed-point angle to Q30 and reduces it modulo two pi into
// (-pi, pi], one conditional subtraction per stage.
// ----------------------------------------------------------------------------
module ffc_angle_mod
	import ffc_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [31:0]      angle,
	output logic signed [ANG_W-1:0] wrapped
);

	localparam int K     = ANG_BITS - FRAC_BITS;
	localparam int MAG_W = 32 + K;
	localparam logic [MAG_W-1:0] T_MAG = MAG_W'(TWO_PI_A);
	localparam logic [32:0] T33  = TWO_PI_A[32:0];

	logic             neg_s [K+1];
	logic [MAG_W-1:0] rem_s [K+1];
	logic [31:0]      abs_in;
	logic [32:0]      m;
	logic [32:0]      fix_s;
	logic signed [ANG_W-1:0] fx;

	assign abs_in = angle[31] ? 32'(-angle) : 32'(angle);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= angle[31];
			rem_s[0] <= {abs_in, {K{1'b0}}};
		end
	end

	for (genvar j = 0; j < K; j++) begin : g_step
		localparam logic [MAG_W-1:0] STEP = T_MAG << (K - 1 - j);
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[j+1] <= neg_s[j];
				rem_s[j+1] <= (rem_s[j] >= STEP) ? rem_s[j] - STEP : rem_s[j];
			end
		end
	end

	assign m  = rem_s[K][32:0];
	assign fx = signed'({2'b00, fix_s});

	always_ff @(posedge clk) begin
		if (en) begin
			fix_s   <= (neg_s[K] && m != 33'd0) ? T33 - m : m;
			wrapped <= (fx > PI_A) ? fx - TWO_PI_A : fx;
		end
	end

endmodule

// File: rtl/ffc_cordic.sv
// ----------------------------------------------------------------------------
// CORDIC pipeline
// One micro-rotation per register stage, in rotation or vectoring mode.
// ----------------------------------------------------------------------------
module ffc_cordic
	import ffc_pkg::*;
#(
	parameter int XY_W      = 33,
	parameter bit VECTORING = 1'b0
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [XY_W-1:0]  x_in,
	input  logic signed [XY_W-1:0]  y_in,
	input  logic signed [ANG_W-1:0] z_in,
	output logic signed [XY_W-1:0]  x_out,
	output logic signed [XY_W-1:0]  y_out,
	output logic signed [ANG_W-1:0] z_out
);

	logic signed [XY_W-1:0]  x_s [CORDIC_STAGES];
	logic signed [XY_W-1:0]  y_s [CORDIC_STAGES];
	logic signed [ANG_W-1:0] z_s [CORDIC_STAGES];

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_it
		logic signed [XY_W-1:0]  xp;
		logic signed [XY_W-1:0]  yp;
		logic signed [ANG_W-1:0] zp;
		logic                    up;
		if (i == 0) begin : g_first
			assign xp = x_in;
			assign yp = y_in;
			assign zp = z_in;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
		end
		assign up = VECTORING ? (yp < 0) : (zp >= 0);
		always_ff @(posedge clk) begin
			if (en) begin
				if (up) begin
					x_s[i] <= xp - (yp >>> i);
					y_s[i] <= yp + (xp >>> i);
					z_s[i] <= zp - ARCTAB[i];
				end else begin
					x_s[i] <= xp + (yp >>> i);
					y_s[i] <= yp - (xp >>> i);
					z_s[i] <= zp + ARCTAB[i];
				end
			end
		end
	end

	assign x_out = x_s[CORDIC_STAGES-1];
	assign y_out = y_s[CORDIC_STAGES-1];
	assign z_out = z_s[CORDIC_STAGES-1];

endmodule
